/* hw/rtl/crc16fbl_pkg.sv */
// ----------------------------------------------------------------------------
// crc16fbl_pkg: shared types and constants of the CRC-16 framed byte link
// Result word layout, register indexes, frame phase and status codes, and the
// byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package crc16fbl_pkg;

    localparam int DATA_W     = 8;
    localparam int CRC_W      = 16;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STATUS_W   = 2;
    localparam int PHASE_W    = 2;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [LEN_W-1:0]  LEN_RESET = 16'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd1;

    // direction values
    localparam logic DIR_TX = 1'b0;

    // frame phase codes
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CRC_HI  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CRC_LO  = 2'd2;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABORT    = 2'd3;

    // one result word
    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic                has_byte;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    // CRC-16/MODBUS update over one byte, LSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc16_framed_byte_link_unit.sv */
// ----------------------------------------------------------------------------
// crc16_framed_byte_link_unit: byte framer with running CRC-16/MODBUS
// Transmit mode appends the CRC (high byte first) after frame_length payload
// bytes; receive mode passes payload and checks the two trailing CRC bytes.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | data_byte, line_error
//  output   | out_valid / out_ready | out_byte, has_byte, frame_status, last
//  config   | cfg_we (no stall)     | cfg_index, cfg_data
//
//  One input word per cycle while in_ready is high; the CRC update is one
//  byte-wide step in the accept cycle. Results are shown from a three-word
//  result register the cycle after acceptance. A frame-ending transmit byte
//  yields three words, so the input stalls until the last is being taken.
//  in_ready is high when the result register is empty or its last word is
//  taken this cycle. Reset clears the frame state and the result register.
// ----------------------------------------------------------------------------
module crc16_framed_byte_link_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [crc16fbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crc16fbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [crc16fbl_pkg::DATA_W-1:0]   data_byte,
    input  logic                              line_error,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [crc16fbl_pkg::DATA_W-1:0]   out_byte,
    output logic                              has_byte,
    output logic [crc16fbl_pkg::STATUS_W-1:0] frame_status,
    output logic                              last
);
    import crc16fbl_pkg::*;

    // configuration and frame state
    logic                direction_reg, direction_next;
    logic [LEN_W-1:0]    frame_length_reg, frame_length_next;
    logic [CRC_W-1:0]    crc_reg, crc_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [DATA_W-1:0]   rx_hi_reg, rx_hi_next;

    // result register: up to three words, word 0 on the ports
    result_t             res_reg [3];
    result_t             res_next [3];
    logic [1:0]          res_cnt_reg, res_cnt_next;

    logic                in_accept;
    logic                pop;
    logic [CRC_W-1:0]    crc_upd;
    logic [LEN_W-1:0]    count_inc;
    logic [DATA_W-1:0]   rx_lo;

    assign out_valid = (res_cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && out_ready);
    assign in_accept = in_valid && in_ready;

    assign out_byte     = res_reg[0].data;
    assign has_byte     = res_reg[0].has_byte;
    assign frame_status = res_reg[0].status;
    assign last         = res_reg[0].last;

    assign crc_upd   = crc16_byte(crc_reg, data_byte);
    assign count_inc = count_reg + 1'b1;
    assign rx_lo     = data_byte;

    // frame state update and result building
    always_comb
    begin
        direction_next    = direction_reg;
        frame_length_next = frame_length_reg;
        crc_next          = crc_reg;
        count_next        = count_reg;
        phase_next        = phase_reg;
        rx_hi_next        = rx_hi_reg;
        res_next          = res_reg;
        res_cnt_next      = res_cnt_reg;

        // drain one word
        if (pop)
        begin
            res_next[0]  = res_reg[1];
            res_next[1]  = res_reg[2];
            res_cnt_next = res_cnt_reg - 2'd1;
        end

        if (cfg_we)
        begin
            if (cfg_index == REG_DIRECTION || cfg_index == REG_FRAME_LENGTH)
            begin
                if (cfg_index == REG_DIRECTION)
                    direction_next = cfg_data[0];
                else
                    frame_length_next = cfg_data[LEN_W-1:0];
                crc_next   = CRC_INIT;
                count_next = '0;
                phase_next = PHASE_PAYLOAD;
                rx_hi_next = '0;
            end
        end
        else if (in_accept)
        begin
            if (line_error)
            begin
                // abort: clear frame, one status word
                crc_next        = CRC_INIT;
                count_next      = '0;
                phase_next      = PHASE_PAYLOAD;
                rx_hi_next      = '0;
                res_next[0]     = '{data: '0, has_byte: 1'b0, status: ST_ABORT, last: 1'b1};
                res_cnt_next    = 2'd1;
            end
            else if (direction_reg == DIR_TX)
            begin
                if (count_inc != frame_length_reg)
                begin
                    crc_next     = crc_upd;
                    count_next   = count_inc;
                    res_next[0]  = '{data: data_byte, has_byte: 1'b1, status: ST_BUSY,
                                     last: 1'b1};
                    res_cnt_next = 2'd1;
                end
                else
                begin
                    // frame end: byte, CRC high, CRC low
                    res_next[0]  = '{data: data_byte, has_byte: 1'b1, status: ST_BUSY,
                                     last: 1'b0};
                    res_next[1]  = '{data: crc_upd[CRC_W-1:DATA_W], has_byte: 1'b1,
                                     status: ST_BUSY, last: 1'b0};
                    res_next[2]  = '{data: crc_upd[DATA_W-1:0], has_byte: 1'b1,
                                     status: ST_GOOD, last: 1'b1};
                    res_cnt_next = 2'd3;
                    crc_next     = CRC_INIT;
                    count_next   = '0;
                    phase_next   = PHASE_PAYLOAD;
                    rx_hi_next   = '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PHASE_CRC_HI:
                    begin
                        rx_hi_next = data_byte;
                        phase_next = PHASE_CRC_LO;
                    end
                    PHASE_CRC_LO:
                    begin
                        res_next[0]  = '{data: '0, has_byte: 1'b0,
                                         status: ({rx_hi_reg, rx_lo} == crc_reg) ?
                                                 ST_GOOD : ST_MISMATCH,
                                         last: 1'b1};
                        res_cnt_next = 2'd1;
                        crc_next     = CRC_INIT;
                        count_next   = '0;
                        phase_next   = PHASE_PAYLOAD;
                        rx_hi_next   = '0;
                    end
                    default:
                    begin
                        crc_next   = crc_upd;
                        count_next = count_inc;
                        if (count_inc == frame_length_reg)
                            phase_next = PHASE_CRC_HI;
                        res_next[0]  = '{data: data_byte, has_byte: 1'b1, status: ST_BUSY,
                                         last: 1'b1};
                        res_cnt_next = 2'd1;
                    end
                endcase
            end
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= DIR_TX;
            frame_length_reg <= LEN_RESET;
            crc_reg          <= CRC_INIT;
            count_reg        <= '0;
            phase_reg        <= PHASE_PAYLOAD;
            rx_hi_reg        <= '0;
            res_cnt_reg      <= 2'd0;
        end
        else
        begin
            direction_reg    <= direction_next;
            frame_length_reg <= frame_length_next;
            crc_reg          <= crc_next;
            count_reg        <= count_next;
            phase_reg        <= phase_next;
            rx_hi_reg        <= rx_hi_next;
            res_cnt_reg      <= res_cnt_next;
        end
    end

    // result words, no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

/* hw/rtl/crc16fbl_checker.sv */
// ----------------------------------------------------------------------------
// crc16fbl_props: port-level checks for the CRC-16 framed byte link
// Watches the output channel for consistent result words and stall behavior.
// ----------------------------------------------------------------------------
module crc16fbl_props (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [crc16fbl_pkg::DATA_W-1:0]   out_byte,
    input  logic                              has_byte,
    input  logic [crc16fbl_pkg::STATUS_W-1:0] frame_status,
    input  logic                              last
);
    import crc16fbl_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
            && $stable(frame_status) && $stable(has_byte))
        else $error("output word changed while stalled");

    // an in-progress word always carries a byte
    a_busy_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == ST_BUSY |-> has_byte)
        else $error("in-progress word without byte");

    // abort word is a bare, final status word
    a_abort_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == ST_ABORT |-> last && !has_byte && out_byte == '0)
        else $error("malformed abort word");

    // a mismatch is the final word of its item and carries no byte
    a_mismatch_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == ST_MISMATCH |-> last && !has_byte)
        else $error("malformed mismatch word");

endmodule

bind crc16_framed_byte_link_unit crc16fbl_props u_crc16fbl_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .frame_status (frame_status),
    .last         (last)
);

/* sim/crc16fbl_checker.sv */
// ----------------------------------------------------------------------------
// crc16fbl_checker: result checker for the CRC-16 framed byte link
// Watches the config port and both channels, keeps its own copy of the frame
// state, predicts the result words of every accepted input word and compares
// each accepted output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module crc16fbl_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crc16fbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crc16fbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [crc16fbl_pkg::DATA_W-1:0]     data_byte,
    input  logic                                line_error,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [crc16fbl_pkg::DATA_W-1:0]     out_byte,
    input  logic                                has_byte,
    input  logic [crc16fbl_pkg::STATUS_W-1:0]   frame_status,
    input  logic                                last,
    output int                                  fail_count,
    output int                                  words_due,
    output int                                  words_checked,
    output logic [crc16fbl_pkg::CRC_W-1:0]      frame_crc
);
    import crc16fbl_pkg::*;

    // shadow configuration and frame state
    logic                dir_mode;
    logic [LEN_W-1:0]    len_cfg;
    logic [CRC_W-1:0]    crc_acc;
    logic [LEN_W-1:0]    byte_cnt;
    logic [PHASE_W-1:0]  phase;
    logic [DATA_W-1:0]   crc_hi_seen;

    // words predicted but not yet seen on the output channel
    result_t             link_words_pending[$];

    // CRC-16/MODBUS over one byte: shift out the low bit, fold in the poly
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] acc,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = acc ^ {8'h00, b};
        repeat (8) begin
            fb = r[0];
            r  = {1'b0, r[CRC_W-1:1]};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic result_t link_word(input logic [DATA_W-1:0] d, input logic h,
                                          input logic [STATUS_W-1:0] s, input logic l);
        result_t w;
        w.data     = d;
        w.has_byte = h;
        w.status   = s;
        w.last     = l;
        return w;
    endfunction

    task automatic frame_clear();
        crc_acc     = CRC_INIT;
        byte_cnt    = '0;
        phase       = PHASE_PAYLOAD;
        crc_hi_seen = '0;
    endtask

    // expected words for one accepted input word
    task automatic frame_predict(input logic [DATA_W-1:0] b, input logic err);
        logic [CRC_W-1:0] rx_crc;
        if (err) begin
            frame_clear();
            link_words_pending.push_back(link_word(8'h00, 1'b0, ST_ABORT, 1'b1));
        end else if (dir_mode == DIR_TX) begin
            crc_acc  = crc_fold(crc_acc, b);
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt != len_cfg) begin
                link_words_pending.push_back(link_word(b, 1'b1, ST_BUSY, 1'b1));
            end else begin
                link_words_pending.push_back(link_word(b, 1'b1, ST_BUSY, 1'b0));
                link_words_pending.push_back(link_word(crc_acc[15:8], 1'b1, ST_BUSY, 1'b0));
                link_words_pending.push_back(link_word(crc_acc[7:0], 1'b1, ST_GOOD, 1'b1));
                frame_clear();
            end
        end else if (phase == PHASE_CRC_HI) begin
            crc_hi_seen = b;
            phase       = PHASE_CRC_LO;
        end else if (phase == PHASE_CRC_LO) begin
            rx_crc = {crc_hi_seen, b};
            link_words_pending.push_back(link_word(8'h00, 1'b0,
                (rx_crc == crc_acc) ? ST_GOOD : ST_MISMATCH, 1'b1));
            frame_clear();
        end else begin
            crc_acc  = crc_fold(crc_acc, b);
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt == len_cfg)
                phase = PHASE_CRC_HI;
            link_words_pending.push_back(link_word(b, 1'b1, ST_BUSY, 1'b1));
        end
    endtask

    // compare, then track config, then predict; all sampled before the edge
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            dir_mode      = DIR_TX;
            len_cfg       = LEN_RESET;
            frame_clear();
            link_words_pending.delete();
            fail_count    = 0;
            words_checked = 0;
        end else begin
            if (out_valid && out_ready) begin
                got = link_word(out_byte, has_byte, frame_status, last);
                if (link_words_pending.size() == 0) begin
                    $display("%0t: unexpected word data=%02h has=%0b st=%0d last=%0b, none expected",
                             $time, got.data, got.has_byte, got.status, got.last);
                    fail_count++;
                end else begin
                    want = link_words_pending.pop_front();
                    words_checked++;
                    if (got.data !== want.data || got.has_byte !== want.has_byte ||
                        got.status !== want.status || got.last !== want.last) begin
                        $display("%0t: word mismatch expected data=%02h has=%0b st=%0d last=%0b",
                                 $time, want.data, want.has_byte, want.status, want.last);
                        $display("%0t:                 actual data=%02h has=%0b st=%0d last=%0b",
                                 $time, got.data, got.has_byte, got.status, got.last);
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_DIRECTION: begin
                        dir_mode = cfg_data[0];
                        frame_clear();
                    end
                    REG_FRAME_LENGTH: begin
                        len_cfg = cfg_data[LEN_W-1:0];
                        frame_clear();
                    end
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                frame_predict(data_byte, line_error);
        end
        words_due = link_words_pending.size();
        frame_crc = crc_acc;
    end

endmodule

/* sim/tb_crc16_framed_byte_link_unit.sv */
// ----------------------------------------------------------------------------
// tb_crc16_framed_byte_link_unit: stimulus and verdict for the CRC-16 framer
// Drives directed and random transmit and receive frames (good, corrupted,
// aborted and broken) through many register settings, with random idling
// on both channels, and takes the pass or fail verdict from the checker.
// ----------------------------------------------------------------------------
module tb_crc16_framed_byte_link_unit;
    import crc16fbl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYC   = 4;
    localparam int HOLD_CYC     = 60;
    localparam int RANDOM_ITEMS = 300;

    // byte source for one input word
    localparam int SRC_DATA   = 0;
    localparam int SRC_CRC_HI = 1;
    localparam int SRC_CRC_LO = 2;

    // indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [DATA_W-1:0]     data_byte  = '0;
    logic                  line_error = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [DATA_W-1:0]     out_byte;
    logic                  has_byte;
    logic [STATUS_W-1:0]   frame_status;
    logic                  last;

    int                    fail_count;
    int                    words_due;
    int                    words_checked;
    logic [CRC_W-1:0]      frame_crc;

    int                    cycles      = 0;
    int                    items_sent  = 0;
    int                    phase_no    = 0;
    bit                    idle_on     = 1'b1;
    bit                    rx_hold_req = 1'b0;
    bit                    cur_rx      = 1'b0;
    int                    cur_len     = 1;

    crc16_framed_byte_link_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .line_error   (line_error),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .frame_status (frame_status),
        .last         (last)
    );

    crc16fbl_checker link_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .line_error    (line_error),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .frame_status  (frame_status),
        .last          (last),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .words_checked (words_checked),
        .frame_crc     (frame_crc)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still due", $time, words_due);
            $display("crc16_framed_byte_link_unit verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
                rx_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // offer one word and hold it until accepted; CRC bytes come from the
    // checker's running CRC, optionally corrupted by flip
    task automatic push_word(input logic [DATA_W-1:0] b, input logic err,
                             input int src, input logic [DATA_W-1:0] flip);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        case (src)
            SRC_CRC_HI: data_byte <= frame_crc[15:8] ^ flip;
            SRC_CRC_LO: data_byte <= frame_crc[7:0] ^ flip;
            default:    data_byte <= b;
        endcase
        line_error <= err;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // stop offering, wait for every result word, then let the block settle
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_due != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_DIRECTION)
            cur_rx = val[0];
        else if (idx == REG_FRAME_LENGTH)
            cur_len = (val[LEN_W-1:0] == 0) ? 65536 : val[LEN_W-1:0];
    endtask

    // one frame in the current mode; with faults it may abort or carry a bad CRC
    task automatic frame_burst(input int nbytes, input bit faults);
        int               span;
        int               err_at;
        logic [DATA_W-1:0] flip_hi;
        logic [DATA_W-1:0] flip_lo;
        bit               stop;
        span    = cur_rx ? nbytes + 2 : nbytes;
        err_at  = -1;
        flip_hi = '0;
        flip_lo = '0;
        stop    = 1'b0;
        if (faults && $urandom_range(0, 19) == 0)
            err_at = $urandom_range(0, span - 1);
        if (faults && $urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1))
                flip_hi = DATA_W'($urandom_range(1, 255));
            else
                flip_lo = DATA_W'($urandom_range(1, 255));
        end
        for (int i = 0; i < span && !stop; i++) begin
            if (i == err_at) begin
                push_word(DATA_W'($urandom_range(0, 255)), 1'b1, SRC_DATA, '0);
                stop = 1'b1;
            end else if (i < nbytes)
                push_word(DATA_W'($urandom_range(0, 255)), 1'b0, SRC_DATA, '0);
            else if (i == nbytes)
                push_word('0, 1'b0, SRC_CRC_HI, flip_hi);
            else
                push_word('0, 1'b0, SRC_CRC_LO, flip_lo);
        end
    endtask

    // payload bytes only, leaving the frame open
    task automatic partial_frame(input int nbytes);
        for (int i = 0; i < nbytes; i++)
            push_word(DATA_W'($urandom_range(0, 255)), 1'b0, SRC_DATA, '0);
    endtask

    initial begin
        int r;
        int nframes;
        int nlen;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings are transmit with one-byte frames
        push_word(8'h00, 1'b0, SRC_DATA, '0);
        push_word(8'hFF, 1'b0, SRC_DATA, '0);
        push_word(8'hA5, 1'b1, SRC_DATA, '0);

        // standard check string, then a transmit frame aborted midway
        cfg_write(REG_FRAME_LENGTH, 9);
        for (int i = 0; i < 9; i++)
            push_word(DATA_W'(8'h31 + i), 1'b0, SRC_DATA, '0);
        partial_frame(2);
        push_word(8'h5A, 1'b1, SRC_DATA, '0);

        // receive: good frame, bad low byte, abort during the CRC bytes
        cfg_write(REG_DIRECTION, 1);
        cfg_write(REG_FRAME_LENGTH, 2);
        push_word(8'h00, 1'b0, SRC_DATA, '0);
        // a write past the register list must leave the open frame alone
        cfg_write(REG_SPARE_A, 16'hFFFF);
        push_word(8'hFF, 1'b0, SRC_DATA, '0);
        push_word('0, 1'b0, SRC_CRC_HI, '0);
        push_word('0, 1'b0, SRC_CRC_LO, '0);
        push_word(8'hFF, 1'b0, SRC_DATA, '0);
        push_word(8'h00, 1'b0, SRC_DATA, '0);
        push_word('0, 1'b0, SRC_CRC_HI, '0);
        push_word('0, 1'b0, SRC_CRC_LO, 8'h80);
        partial_frame(2);
        push_word('0, 1'b0, SRC_CRC_HI, '0);
        push_word(8'h00, 1'b1, SRC_DATA, '0);
        cfg_write(REG_SPARE_B, 0);

        // random phases of settings and frames
        while (items_sent < RANDOM_ITEMS) begin
            phase_no++;
            idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            nlen = (r == 0) ? 1 : (r == 1) ? $urandom_range(12, 24) : $urandom_range(2, 6);
            if ($urandom_range(0, 1)) begin
                cfg_write(REG_DIRECTION, $urandom_range(0, 1));
                cfg_write(REG_FRAME_LENGTH, nlen);
            end else begin
                cfg_write(REG_FRAME_LENGTH, nlen);
                if ($urandom_range(0, 2) != 0)
                    cfg_write(REG_DIRECTION, $urandom_range(0, 1));
            end
            if ($urandom_range(0, 5) == 0)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          $urandom_range(0, 65535));
            // long receiver hold while the sender keeps offering
            if (phase_no == 3)
                rx_hold_req = 1'b1;
            nframes = $urandom_range(2, 5);
            for (int f = 0; f < nframes; f++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise, then a line error to realign the frame
                    repeat ($urandom_range(3, 8))
                        push_word(DATA_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 5) == 0, SRC_DATA, '0);
                    push_word(DATA_W'($urandom_range(0, 255)), 1'b1, SRC_DATA, '0);
                end else begin
                    frame_burst(cur_len, 1'b1);
                end
                // sender waits for every result before going on
                if (phase_no == 5 || $urandom_range(0, 19) == 0)
                    wait_drain();
            end
            // leave a frame open so the next write has to clear it
            if ($urandom_range(0, 2) == 0)
                partial_frame($urandom_range(0, cur_len - 1));
        end

        // last part: no idling; widest frame lengths left open, then small frames
        wait_drain();
        idle_on = 1'b0;
        cfg_write(REG_DIRECTION, 0);
        cfg_write(REG_FRAME_LENGTH, 0);
        partial_frame(6);
        cfg_write(REG_DIRECTION, 1);
        cfg_write(REG_FRAME_LENGTH, 65535);
        partial_frame(6);
        push_word(8'hC3, 1'b1, SRC_DATA, '0);
        cfg_write(REG_FRAME_LENGTH, 5);
        for (int f = 0; f < 6; f++)
            frame_burst(cur_len, 1'b1);
        cfg_write(REG_DIRECTION, 0);
        cfg_write(REG_FRAME_LENGTH, 1);
        for (int f = 0; f < 6; f++)
            frame_burst(cur_len, 1'b1);

        wait_drain();
        $display("ran %0d input words over %0d random phases; %0d result words checked",
                 items_sent, phase_no, words_checked);
        $display("covered tx/rx frames of 1 to 24 bytes, open frames at lengths 0 and 65535,");
        $display("bad CRCs, aborts and noise");
        if (fail_count == 0)
            $display("crc16_framed_byte_link_unit verification clean");
        else
            $display("crc16_framed_byte_link_unit verification failed");
        $finish;
    end

endmodule
